[rtl/b64e_pkg.sv]
// shared types, constants and the symbol alphabet for the base64 encoder
`default_nettype none

package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int SYM_W  = 6;
    localparam int CHAR_W = 7;
    localparam int MAX_CHARS = 4;

    // number of leftover bit pairs held between bytes
    localparam logic [1:0] PAIRS_NONE = 2'd0;
    localparam logic [1:0] PAIRS_ONE  = 2'd1;
    localparam logic [1:0] PAIRS_TWO  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 7'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 7'h2F;
    localparam logic [CHAR_W-1:0] CHAR_PAD     = 7'h3D;

    // one queue entry: the characters caused by one byte
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [1:0]                       last_idx;
        logic                             eom;
    } entry_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } q_stat_t;

    function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] sym);
        logic [CHAR_W-1:0] s;
        logic [CHAR_W-1:0] ch;
        s = CHAR_W'(sym);
        if (sym < 6'd26)
            ch = CHAR_UPPER_A + s;
        else if (sym < 6'd52)
            ch = CHAR_LOWER_A + s - 7'd26;
        else if (sym < 6'd62)
            ch = CHAR_DIGIT_0 + s - 7'd52;
        else if (sym == 6'd62)
            ch = CHAR_PLUS;
        else
            ch = CHAR_SLASH;
        return ch;
    endfunction

endpackage

`default_nettype wire

[rtl/b64e_if.sv]
// word channels for raw bytes in and base64 characters out
`default_nettype none

interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       end_of_text;

    modport source (output valid, output out_char, output end_of_text, input ready);
    modport sink (input valid, input out_char, input end_of_text, output ready);
endinterface

`default_nettype wire

[rtl/b64e_front.sv]
// front end: takes bytes, splits them into symbols and queues the characters
`default_nettype none

module b64e_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    b64e_byte_if.sink             raw,
    input  wire b64e_pkg::q_stat_t q_stat,
    output logic                  push,
    output b64e_pkg::entry_t      entry
);

    logic [3:0] bits_reg;
    logic [3:0] bits_next;
    logic [1:0] pairs_reg;
    logic [1:0] pairs_next;
    logic [1:0] pairs;
    logic [7:0] b;

    assign raw.ready = !q_stat.full;
    assign push      = raw.valid && raw.ready;
    assign b         = raw.data_byte;

    always_comb
    begin
        pairs = (pairs_reg == 2'd3) ? b64e_pkg::PAIRS_NONE : pairs_reg;
        entry = '0;
        bits_next  = bits_reg;
        pairs_next = pairs_reg;
        case (pairs)
            b64e_pkg::PAIRS_ONE:
            begin
                entry.chars[0] = b64e_pkg::sym_to_char({bits_reg[1:0], b[7:4]});
                bits_next  = b[3:0];
                pairs_next = b64e_pkg::PAIRS_TWO;
                if (raw.is_last)
                begin
                    entry.chars[1] = b64e_pkg::sym_to_char({b[3:0], 2'b00});
                    entry.chars[2] = b64e_pkg::CHAR_PAD;
                    entry.last_idx = 2'd2;
                end
                else
                begin
                    entry.last_idx = 2'd0;
                end
            end
            b64e_pkg::PAIRS_TWO:
            begin
                entry.chars[0] = b64e_pkg::sym_to_char({bits_reg, b[7:6]});
                entry.chars[1] = b64e_pkg::sym_to_char(b[5:0]);
                entry.last_idx = 2'd1;
                bits_next  = 4'd0;
                pairs_next = b64e_pkg::PAIRS_NONE;
            end
            default:
            begin
                entry.chars[0] = b64e_pkg::sym_to_char(b[7:2]);
                bits_next  = {2'b00, b[1:0]};
                pairs_next = b64e_pkg::PAIRS_ONE;
                if (raw.is_last)
                begin
                    entry.chars[1] = b64e_pkg::sym_to_char({b[1:0], 4'b0000});
                    entry.chars[2] = b64e_pkg::CHAR_PAD;
                    entry.chars[3] = b64e_pkg::CHAR_PAD;
                    entry.last_idx = 2'd3;
                end
                else
                begin
                    entry.last_idx = 2'd0;
                end
            end
        endcase
        entry.eom = raw.is_last;
        if (raw.is_last)
        begin
            bits_next  = 4'd0;
            pairs_next = b64e_pkg::PAIRS_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg  <= 4'd0;
            pairs_reg <= b64e_pkg::PAIRS_NONE;
        end
        else if (push)
        begin
            bits_reg  <= bits_next;
            pairs_reg <= pairs_next;
        end
    end

endmodule

`default_nettype wire

[rtl/b64e_queue.sv]
// short queue of character groups between front and back end
`default_nettype none

module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH  // at least 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire b64e_pkg::entry_t  wr_entry,
    input  wire logic              pop,
    output b64e_pkg::entry_t       head,
    output b64e_pkg::q_stat_t      q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign do_pop            = pop && (count_reg != '0);
    assign q_stat.full       = (count_reg == CNT_W'(DEPTH));
    assign q_stat.head_valid = (count_reg != '0);
    assign head              = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/b64e_back.sv]
// back end: sends the queued characters one word per cycle while text is ready
`default_nettype none

module b64e_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire b64e_pkg::entry_t  head,
    input  wire b64e_pkg::q_stat_t q_stat,
    output logic                   pop,
    b64e_char_if.source            text
);

    logic [1:0]                  idx_reg;
    logic [1:0]                  idx_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic [b64e_pkg::CHAR_W-1:0] char_reg;
    logic                        eot_reg;
    logic                        load;
    logic                        at_end;

    assign load   = q_stat.head_valid && (!valid_reg || text.ready);
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (text.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= head.chars[idx_reg];
            eot_reg  <= head.eom && at_end;
        end
    end

    assign text.valid       = valid_reg;
    assign text.out_char    = char_reg;
    assign text.end_of_text = eot_reg;

endmodule

`default_nettype wire

[rtl/base64_encoder.sv]
// top level of the streaming base64 encoder
//
// raw: one byte per word, with is_last on the final byte of a message.
// text: one base64 character per word (A-Z a-z 0-9 + / and = padding),
//   end_of_text set on the last character of the encoded message.
// the front end splits each byte against the leftover bits of the
// previous ones and queues the one to four characters it causes; the
// back end drains the queue through an output register.
// a taken byte is written into the queue, and the back end then loads
//   its first character into the output register.
// throughput: one character per cycle while text is ready, set by the
//   output register; a byte gives one or two characters (four per three
//   bytes), the last byte of a message up to four.
// raw.ready drops only when the queue is full; a stalled text channel
//   holds its word and fills the queue before input is held off.
// reset clears the leftover bits, empties the queue and clears the output valid flag.
`default_nettype none

module base64_encoder #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    b64e_byte_if.sink   raw,
    b64e_char_if.source text
);

    b64e_pkg::entry_t  wr_entry;
    b64e_pkg::entry_t  head;
    b64e_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;

    b64e_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .raw    (raw),
        .q_stat (q_stat),
        .push   (push),
        .entry  (wr_entry)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    b64e_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .text   (text)
    );

endmodule

`default_nettype wire

[rtl/b64e_checker.sv]
// port checker for the base64 encoder and its bind
`default_nettype none

module b64e_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       text_valid,
    input wire logic       text_ready,
    input wire logic [6:0] out_char,
    input wire logic       end_of_text
);

    logic is_pad;
    logic is_legal;

    assign is_pad   = (out_char == b64e_pkg::CHAR_PAD);
    assign is_legal = (out_char >= 7'h41 && out_char <= 7'h5A)
                   || (out_char >= 7'h61 && out_char <= 7'h7A)
                   || (out_char >= 7'h30 && out_char <= 7'h39)
                   || (out_char == b64e_pkg::CHAR_PLUS)
                   || (out_char == b64e_pkg::CHAR_SLASH)
                   || is_pad;

    // no word leaves during reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !text_valid)
        else $error("text valid during reset");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(out_char)
            && $stable(end_of_text))
        else $error("stalled text word changed");

    a_legal: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid |-> is_legal)
        else $error("character outside the base64 alphabet");

    // a pad that does not end the text is followed at once by another pad
    a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && is_pad && !end_of_text
            |=> text_valid && is_pad)
        else $error("padding run broken");

endmodule

bind base64_encoder b64e_checker u_b64e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .text_valid  (text.valid),
    .text_ready  (text.ready),
    .out_char    (text.out_char),
    .end_of_text (text.end_of_text)
);

`default_nettype wire

[bench/testbench.sv]
// self-checking bench for the streaming base64 encoder, byte words in, character words out
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [b64e_pkg::CHAR_W-1:0] ch;
        logic                        eot;
    } b64_char_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        string      typed;
    } byte_row_t;

    localparam string B64_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int HOLD_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n;

    b64e_byte_if raw_if ();
    b64e_char_if text_if ();

    base64_encoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_if),
        .text  (text_if)
    );

    always #5 clk = ~clk;

    // encoder state as predicted
    logic [3:0] carry_bits;
    logic [1:0] carry_pairs;

    b64_char_t fresh_chars[$];
    b64_char_t pending_chars[$];

    int errors = 0;
    int bytes_sent = 0;
    int messages_sent = 0;
    int chars_checked = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;

    // stimulus table; a blank string means the predictor supplies the characters
    byte_row_t directed_rows[21] = '{
        '{8'h00, 1'b1, "AA=="},
        '{8'hFF, 1'b1, "/w=="},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b1, "/8="},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b1, "//"},
        '{8'h00, 1'b0, "A"},
        '{8'h00, 1'b0, "A"},
        '{8'h00, 1'b1, "AA"},
        '{8'h4D, 1'b0, "T"},
        '{8'h61, 1'b0, "W"},
        '{8'h6E, 1'b1, "Fu"},
        '{8'hFB, 1'b0, ""},
        '{8'hEF, 1'b0, ""},
        '{8'hBE, 1'b1, ""},
        '{8'hAA, 1'b0, ""},
        '{8'h55, 1'b0, ""},
        '{8'h80, 1'b0, ""},
        '{8'h01, 1'b0, ""},
        '{8'h7F, 1'b1, ""}
    };

    task automatic flag_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic logic [b64e_pkg::CHAR_W-1:0] symbol_char(input logic [5:0] sym);
        byte c;
        c = B64_SYMBOLS[sym];
        return c[b64e_pkg::CHAR_W-1:0];
    endfunction

    // splits one byte against the carried bits and fills fresh_chars
    function automatic void encode_byte(input logic [7:0] data, input logic last);
        logic [11:0] acc;
        logic [5:0]  sym;
        int          nbits;
        int          pads;
        b64_char_t   c;
        fresh_chars.delete();
        nbits = (carry_pairs > b64e_pkg::PAIRS_TWO) ? 8 : 2 * int'(carry_pairs) + 8;
        acc = {carry_bits, data} & ((12'd1 << nbits) - 12'd1);
        while (nbits >= 6)
        begin
            sym = 6'(acc >> (nbits - 6));
            fresh_chars.push_back('{ch: symbol_char(sym), eot: 1'b0});
            nbits -= 6;
            acc &= (12'd1 << nbits) - 12'd1;
        end
        if (!last)
        begin
            carry_bits = acc[3:0];
            carry_pairs = 2'(nbits / 2);
            return;
        end
        if (nbits > 0)
        begin
            sym = 6'(acc << (6 - nbits));
            fresh_chars.push_back('{ch: symbol_char(sym), eot: 1'b0});
            pads = (nbits == 2) ? 2 : 1;
            repeat (pads) fresh_chars.push_back('{ch: b64e_pkg::CHAR_PAD, eot: 1'b0});
        end
        c = fresh_chars[$];
        c.eot = 1'b1;
        fresh_chars[fresh_chars.size() - 1] = c;
        carry_bits = '0;
        carry_pairs = b64e_pkg::PAIRS_NONE;
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic last, input string typed);
        int  i;
        byte tc;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            raw_if.valid <= 1'b0;
            @(posedge clk);
        end
        raw_if.valid <= 1'b1;
        raw_if.data_byte <= data;
        raw_if.is_last <= last;
        do @(posedge clk); while (!raw_if.ready);
        encode_byte(data, last);
        if (typed.len() == 0)
        begin
            foreach (fresh_chars[k]) pending_chars.push_back(fresh_chars[k]);
        end
        else
        begin
            for (i = 0; i < typed.len(); i++)
            begin
                tc = typed[i];
                pending_chars.push_back('{ch: tc[b64e_pkg::CHAR_W-1:0],
                                          eot: last && (i == typed.len() - 1)});
            end
        end
        bytes_sent++;
        if (last)
            messages_sent++;
    endtask

    task automatic random_message(input int len);
        int j;
        for (j = 0; j < len; j++)
            send_byte(8'($urandom_range(255)), j == len - 1, "");
    endtask

    // character sink: check, then choose ready for the next cycle
    initial
    begin
        b64_char_t want;
        text_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && text_if.valid && text_if.ready)
            begin
                chars_checked++;
                if (pending_chars.size() == 0)
                    flag_mismatch($sformatf("unexpected char 0x%02h eot %0b",
                                            text_if.out_char, text_if.end_of_text));
                else
                begin
                    want = pending_chars.pop_front();
                    if (text_if.out_char !== want.ch || text_if.end_of_text !== want.eot)
                        flag_mismatch($sformatf("char 0x%02h eot %0b, wanted 0x%02h eot %0b",
                                                text_if.out_char, text_if.end_of_text,
                                                want.ch, want.eot));
                end
            end
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                text_if.ready <= 1'b0;
            end
            else
                text_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        int phase;
        int phase_start;
        int len;
        rst_n = 1'b0;
        raw_if.valid = 1'b0;
        raw_if.data_byte = '0;
        raw_if.is_last = 1'b0;
        carry_bits = '0;
        carry_pairs = b64e_pkg::PAIRS_NONE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed);

        // long sink hold-off while bytes keep coming
        hold_request = 1'b1;
        random_message(12);
        raw_if.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 40)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(1, 6);
                random_message(len);
            end
        end

        raw_if.valid <= 1'b0;
        sink_stall_pct = 0;
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d bytes in %0d messages, %0d characters checked",
                 bytes_sent, messages_sent, chars_checked);
        $display("all three tail cases, sink hold-off with input back-pressure, four idle mixes");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d characters outstanding", pending_chars.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
